[sv/pfa_pkg.sv]
// Shared types and constants of the prefetch filter with accuracy tracking.
`default_nettype none

package pfa_pkg;

  // Operation codes carried by each input word.
  typedef enum logic [2:0] {
    OP_QUERY  = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_USEFUL = 3'd3,
    OP_ISSUE  = 3'd4
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  // Accuracy is an unsigned Q0.8 fraction; 230 stands for 0.9.
  localparam int unsigned ACC_BITS     = 8;
  localparam int unsigned ACC_CNT_W    = 3;
  localparam logic [7:0]  ACC_FALLBACK = 8'd230;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic rd_en;
    logic upd_en;
    logic div_load;
    logic div_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

[sv/pfa_div.sv]
// Bit-serial restoring divider that forms useful * 256 / total as Q0.8.
`default_nettype none

module pfa_div #(
  parameter int unsigned NUM_W = 10,
  parameter int unsigned DEN_W = 10
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [7:0]       quot_o,
  output logic                  last_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [DEN_W-1:0]              rem_q, rem_d;
  logic [DEN_W-1:0]              den_q;
  logic [pfa_pkg::ACC_BITS-1:0]  quot_q, quot_d;
  logic [pfa_pkg::ACC_CNT_W-1:0] cnt_q;
  logic                          fb_q;
  logic                          fb_d;
  logic [DEN_W:0]                two_rem;
  logic                          ge;

  // The fallback applies when nothing was issued or the ratio reaches one.
  assign fb_d = (den_i == '0) || (CMP_W'(num_i) >= CMP_W'(den_i));

  // One quotient bit per step: double the remainder and try to subtract.
  always_comb begin
    two_rem = {rem_q, 1'b0};
    ge      = two_rem >= {1'b0, den_q};
    rem_d   = ge ? DEN_W'(two_rem - {1'b0, den_q}) : DEN_W'(two_rem);
    quot_d  = {quot_q[pfa_pkg::ACC_BITS-2:0], ge};
  end

  // Working registers; the remainder fits in DEN_W bits whenever the
  // fallback is not taken.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q  <= DEN_W'(num_i);
      den_q  <= den_i;
      quot_q <= '0;
      fb_q   <= fb_d;
    end else if (step_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign last_o = step_i && (cnt_q == pfa_pkg::ACC_CNT_W'(pfa_pkg::ACC_BITS - 1));
  assign quot_o = fb_q ? pfa_pkg::ACC_FALLBACK : quot_q;

endmodule

`default_nettype wire

[sv/pfa_dp.sv]
// Datapath: filter table memory, lookup and replacement, counters, divider.
`default_nettype none

module pfa_dp #(
  parameter int unsigned SETS        = 1024,
  parameter int unsigned WAYS        = 1,
  parameter int unsigned TAG_BITS    = 10,
  parameter int unsigned TOTAL_BITS  = 10,
  parameter int unsigned USEFUL_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pfa_pkg::cmd_t          cmd_i,
  output pfa_pkg::sts_t               sts_o,
  input  wire logic [2:0]             opcode_i,
  input  wire logic [57:0]            line_addr_i,
  output logic                        hit_o,
  output logic                        collision_o,
  output logic [7:0]                  accuracy_o,
  output logic [USEFUL_BITS-1:0]      useful_o,
  output logic [TOTAL_BITS-1:0]       total_o,
  output logic [31:0]                 coll_cnt_o
);

  // SETS is a power of two: the set index is the low address bits.
  localparam int unsigned SET_W = $clog2(SETS);
  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned ENT_W = TAG_BITS + 2;
  localparam int unsigned ROW_W = WAYS * ENT_W;

  // One memory row holds a whole set; each way is {valid, useful, tag}.
  logic [ROW_W-1:0] mem_q [SETS];
  logic [ROW_W-1:0] rd_row_q;
  logic [ROW_W-1:0] row_new;
  logic [ROW_W-1:0] wr_data;
  logic [SET_W-1:0] wr_addr;
  logic             wr_en;

  logic [2:0]             op_q;
  logic [SET_W-1:0]       set_q;
  logic [TAG_BITS-1:0]    tag_q;
  logic [SET_W-1:0]       clr_addr_q;

  logic [TOTAL_BITS-1:0]  total_q, total_d;
  logic [USEFUL_BITS-1:0] useful_q, useful_d;
  logic [31:0]            coll_cnt_q, coll_cnt_d;
  logic [WAY_W-1:0]       victim_q, victim_d;
  logic                   hit_q;
  logic                   coll_q, coll_d;
  logic                   div_last;

  logic [WAYS-1:0]        valid_vec;
  logic [WAYS-1:0]        use_vec;
  logic [WAYS-1:0]        hit_vec;
  logic [WAY_W-1:0]       free_way;
  logic [WAY_W-1:0]       ins_way;
  logic                   any_hit;
  logic                   any_free;
  logic                   hit_useful;

  // Latch the input word when it is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      set_q <= line_addr_i[SET_W-1:0];
      tag_q <= line_addr_i[SET_W +: TAG_BITS];
    end
  end

  // Row pointer of the clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Status back to the controller.
  assign sts_o = '{clr_last: (clr_addr_q == SET_W'(SETS - 1)), div_last: div_last};

  // Table memory: one write port, one registered read port.
  assign wr_en   = cmd_i.clr_we || cmd_i.upd_en;
  assign wr_addr = cmd_i.clr_we ? clr_addr_q : set_q;
  assign wr_data = cmd_i.clr_we ? '0 : row_new;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_row_q <= mem_q[set_q];
    end
  end

  // Tag compare across the ways of the set and search for a free way.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid_vec[w] = rd_row_q[w*ENT_W + ENT_W - 1];
      use_vec[w]   = rd_row_q[w*ENT_W + TAG_BITS];
      hit_vec[w]   = valid_vec[w] && (rd_row_q[w*ENT_W +: TAG_BITS] == tag_q);
    end
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
    any_hit    = |hit_vec;
    any_free   = ~&valid_vec;
    hit_useful = |(hit_vec & use_vec);
    ins_way    = any_free ? free_way : victim_q;
  end

  // Apply the operation to the set row and to the counters.
  always_comb begin
    row_new    = rd_row_q;
    total_d    = total_q;
    useful_d   = useful_q;
    coll_cnt_d = coll_cnt_q;
    victim_d   = victim_q;
    coll_d     = 1'b0;
    case (op_q)
      pfa_pkg::OP_INSERT: begin
        if (!any_hit) begin
          for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == ins_way) begin
              row_new[w*ENT_W +: ENT_W] = {1'b1, 1'b0, tag_q};
            end
          end
          if (!any_free) begin
            coll_d     = 1'b1;
            coll_cnt_d = coll_cnt_q + 32'd1;
            victim_d   = (victim_q == WAY_W'(WAYS - 1)) ? '0 : WAY_W'(victim_q + 1'b1);
          end
        end
      end
      pfa_pkg::OP_REMOVE: begin
        for (int w = 0; w < WAYS; w++) begin
          if (hit_vec[w]) begin
            row_new[w*ENT_W + ENT_W - 1] = 1'b0;
            row_new[w*ENT_W + TAG_BITS]  = 1'b0;
          end
        end
      end
      pfa_pkg::OP_USEFUL: begin
        if (any_hit && !hit_useful) begin
          for (int w = 0; w < WAYS; w++) begin
            if (hit_vec[w]) begin
              row_new[w*ENT_W + TAG_BITS] = 1'b1;
            end
          end
          useful_d = useful_q + 1'b1;
        end
      end
      pfa_pkg::OP_ISSUE: begin
        total_d = total_q + 1'b1;
        // On wrap of the issued count, the useful count restarts at one.
        if (total_d == '0) begin
          useful_d = USEFUL_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Counters and replacement pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      useful_q   <= '0;
      coll_cnt_q <= '0;
      victim_q   <= '0;
    end else if (cmd_i.upd_en) begin
      total_q    <= total_d;
      useful_q   <= useful_d;
      coll_cnt_q <= coll_cnt_d;
      victim_q   <= victim_d;
    end
  end

  // Per-word result flags.
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_en) begin
      hit_q  <= any_hit;
      coll_q <= coll_d;
    end
  end

  // Accuracy divider, loaded from the counters after the update.
  pfa_div #(
    .NUM_W (USEFUL_BITS),
    .DEN_W (TOTAL_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cmd_i.div_load),
    .step_i (cmd_i.div_step),
    .num_i  (useful_q),
    .den_i  (total_q),
    .quot_o (accuracy_o),
    .last_o (div_last)
  );

  assign hit_o       = hit_q;
  assign collision_o = coll_q;
  assign useful_o    = useful_q;
  assign total_o     = total_q;
  assign coll_cnt_o  = coll_cnt_q;

endmodule

`default_nettype wire

[sv/pfa_ctrl.sv]
// Controller state machine: clearing pass, lookup, update, divide, result.
`default_nettype none

module pfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               valid_o,
  output pfa_pkg::cmd_t      cmd_o,
  input  wire pfa_pkg::sts_t sts_i
);

  pfa_pkg::state_e state_q, state_d;

  // State register; reset starts with the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfa_pkg::ST_CLEAR:  if (sts_i.clr_last) state_d = pfa_pkg::ST_IDLE;
      pfa_pkg::ST_IDLE:   if (start) state_d = pfa_pkg::ST_READ;
      pfa_pkg::ST_READ:   state_d = pfa_pkg::ST_UPDATE;
      pfa_pkg::ST_UPDATE: state_d = pfa_pkg::ST_DLOAD;
      pfa_pkg::ST_DLOAD:  state_d = pfa_pkg::ST_DIV;
      pfa_pkg::ST_DIV:    if (sts_i.div_last) state_d = pfa_pkg::ST_DONE;
      pfa_pkg::ST_DONE:   state_d = pfa_pkg::ST_IDLE;
      default:            state_d = pfa_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o   = '0;
    busy    = 1'b1;
    valid_o = 1'b0;
    unique case (state_q)
      pfa_pkg::ST_CLEAR:  cmd_o.clr_we = 1'b1;
      pfa_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.capture = start;
      end
      pfa_pkg::ST_READ:   cmd_o.rd_en    = 1'b1;
      pfa_pkg::ST_UPDATE: cmd_o.upd_en   = 1'b1;
      pfa_pkg::ST_DLOAD:  cmd_o.div_load = 1'b1;
      pfa_pkg::ST_DIV:    cmd_o.div_step = 1'b1;
      pfa_pkg::ST_DONE:   valid_o        = 1'b1;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/prefetch_filter_accuracy.sv]
// Top level of the prefetch filter with accuracy tracking.
// Each accepted word passes the read, update, divider-load, divide and done states in order;
// valid_o is high in done. Busy holds new words off until idle, through the 8-step serial divide.
// Reset: counters clear at once, then a clearing pass empties the table memory
// one set per cycle, with busy high throughout.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module prefetch_filter_accuracy #(
  parameter int unsigned SETS        = 1024,
  parameter int unsigned WAYS        = 1,
  parameter int unsigned TAG_BITS    = 10,
  parameter int unsigned TOTAL_BITS  = 10,
  parameter int unsigned USEFUL_BITS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [57:0] line_addr_i,
  output logic             valid_o,
  output logic             hit_o,
  output logic             collision_o,
  output logic [7:0]       accuracy_q8_o,
  output logic [9:0]       useful_count_o,
  output logic [9:0]       total_count_o,
  output logic [31:0]      collision_count_o
);

  pfa_pkg::cmd_t          cmd;
  pfa_pkg::sts_t          sts;
  logic [USEFUL_BITS-1:0] useful;
  logic [TOTAL_BITS-1:0]  total;

  pfa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .valid_o (valid_o),
    .cmd_o   (cmd),
    .sts_i   (sts)
  );

  pfa_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .TAG_BITS    (TAG_BITS),
    .TOTAL_BITS  (TOTAL_BITS),
    .USEFUL_BITS (USEFUL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode_i),
    .line_addr_i (line_addr_i),
    .hit_o       (hit_o),
    .collision_o (collision_o),
    .accuracy_o  (accuracy_q8_o),
    .useful_o    (useful),
    .total_o     (total),
    .coll_cnt_o  (collision_count_o)
  );

  // Counts are reported in ten bits.
  assign useful_count_o = 10'(useful);
  assign total_count_o  = 10'(total);

endmodule

`default_nettype wire
